// ===== hw/rtl/msol_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package msol_pkg;

   // request word types
   localparam logic [2:0] REQ_WRITE = 3'd0;
   localparam logic [2:0] REQ_READ  = 3'd1;
   localparam logic [2:0] REQ_BYTE  = 3'd2;
   localparam logic [2:0] REQ_DRAIN = 3'd3;
   localparam logic [2:0] REQ_TICK  = 3'd4;

   // link status codes
   localparam logic [2:0] ST_NONE    = 3'd0;
   localparam logic [2:0] ST_WAIT    = 3'd1;
   localparam logic [2:0] ST_SUCCESS = 3'd2;
   localparam logic [2:0] ST_ERROR   = 3'd3;
   localparam logic [2:0] ST_BUSY    = 3'd4;

   localparam logic [7:0]  OP_READ   = 8'h10;
   localparam logic [7:0]  OP_WRITE  = 8'h11;
   localparam logic [7:0]  ACK_OK    = 8'h4F;  // 'O'
   localparam logic [7:0]  ACK_FAIL  = 8'h46;  // 'F'
   localparam logic [15:0] CRC_POLY  = 16'h1021;
   localparam logic [15:0] CRC_MSB   = 16'h8000;
   localparam logic [15:0] TIMEOUT_RESET = 16'd500;
   localparam int          FRAME_MAX = 11;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [15:0] object_index;
      logic [7:0]  object_subindex;
      logic [7:0]  node_id;
      logic [31:0] write_value;
      logic [7:0]  rx_byte;
   } msol_req_type;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        last;
      logic [2:0]  link_status;
      logic [31:0] reply_error_code;
      logic [31:0] reply_data;
   } msol_rsp_type;

   // everything one request word produces; count 0 means a single word without tx
   typedef struct packed {
      logic [3:0]                     count;
      logic [FRAME_MAX-1:0][7:0]      bytes;
      logic [2:0]                     status;
      logic [31:0]                    err;
      logic [31:0]                    dat;
   } msol_desc_type;

   // one byte through CRC-16, MSB first
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC_MSB) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/msol_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msol_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  wire msol_pkg::msol_req_type req,
   input  wire logic                   csr_wr_en,
   input  wire logic [15:0]            csr_wr_data,
   output msol_pkg::msol_desc_type     desc
);

   typedef enum logic [3:0] {
      PH_READY, PH_SEND_OP, PH_WAIT_BACK, PH_SEND_FRAME, PH_WAIT_EACK,
      PH_WAIT_ROP, PH_SEND_RBACK, PH_WAIT_RPAY, PH_SEND_REACK
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] timeout_ff;
   logic [15:0] ticks_ff, ticks_in;
   logic [2:0]  held_ff, held_in;
   logic [3:0]  rc_ff, rc_in;
   logic [3:0]  exp_ff, exp_in;
   logic        ack_ok_ff, ack_ok_in;
   logic        is_wr_ff, is_wr_in;
   logic [8:0][7:0] out_ff, out_in;   // outbound frame less its CRC
   logic [8:1][7:0] inb_ff, inb_in;   // inbound bytes that hold the two dwords
   logic [15:0] rcrc_ff, rcrc_in;
   logic [7:0]  pend_ff, pend_in;
   logic [15:0] ocrc;
   logic        rejected;
   logic        coll;
   logic [2:0]  st;
   logic [7:0]  b;

   assign b = req.rx_byte;

   // outbound CRC over opcode, length byte, then each word high byte first
   always_comb begin
      ocrc = msol_pkg::crc_step(16'h0000, is_wr_ff ? msol_pkg::OP_WRITE : msol_pkg::OP_READ);
      ocrc = msol_pkg::crc_step(ocrc, out_ff[0]);
      ocrc = msol_pkg::crc_step(msol_pkg::crc_step(ocrc, out_ff[2]), out_ff[1]);
      ocrc = msol_pkg::crc_step(msol_pkg::crc_step(ocrc, out_ff[4]), out_ff[3]);
      if (is_wr_ff) begin
         ocrc = msol_pkg::crc_step(msol_pkg::crc_step(ocrc, out_ff[6]), out_ff[5]);
         ocrc = msol_pkg::crc_step(msol_pkg::crc_step(ocrc, out_ff[8]), out_ff[7]);
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      ticks_in  = ticks_ff;
      held_in   = held_ff;
      rc_in     = rc_ff;
      exp_in    = exp_ff;
      ack_ok_in = ack_ok_ff;
      is_wr_in  = is_wr_ff;
      out_in    = out_ff;
      inb_in    = inb_ff;
      rcrc_in   = rcrc_ff;
      pend_in   = pend_ff;
      rejected  = 1'b0;
      coll      = 1'b0;
      desc      = '0;

      unique case (req.req_type) inside
         msol_pkg::REQ_WRITE, msol_pkg::REQ_READ: begin
            if (phase_ff != PH_READY) begin
               rejected = 1'b1;
            end else begin
               is_wr_in  = (req.req_type == msol_pkg::REQ_WRITE);
               out_in[0] = is_wr_in ? 8'd3 : 8'd1;
               out_in[1] = req.object_index[7:0];
               out_in[2] = req.object_index[15:8];
               out_in[3] = req.object_subindex;
               out_in[4] = req.node_id;
               out_in[5] = req.write_value[7:0];
               out_in[6] = req.write_value[15:8];
               out_in[7] = req.write_value[23:16];
               out_in[8] = req.write_value[31:24];
               exp_in    = is_wr_in ? 4'd7 : 4'd11;
               rc_in     = 4'd0;
               ack_ok_in = 1'b0;
               phase_in  = PH_SEND_OP;
               held_in   = msol_pkg::ST_WAIT;
               ticks_in  = timeout_ff;
               desc.count    = 4'd1;
               desc.bytes[0] = is_wr_in ? msol_pkg::OP_WRITE : msol_pkg::OP_READ;
            end
         end
         msol_pkg::REQ_BYTE: begin
            unique case (phase_ff) inside
               PH_SEND_OP, PH_WAIT_BACK: begin
                  if (b == msol_pkg::ACK_OK) begin
                     for (int k = 0; k < 5; k++) desc.bytes[k] = out_ff[k];
                     if (is_wr_ff) begin
                        for (int k = 5; k < 9; k++) desc.bytes[k] = out_ff[k];
                        desc.bytes[9]  = ocrc[7:0];
                        desc.bytes[10] = ocrc[15:8];
                        desc.count     = 4'd11;
                     end else begin
                        desc.bytes[5] = ocrc[7:0];
                        desc.bytes[6] = ocrc[15:8];
                        desc.count    = 4'd7;
                     end
                     phase_in = PH_SEND_FRAME;
                     ticks_in = timeout_ff;
                  end else begin
                     phase_in = PH_READY;
                     held_in  = msol_pkg::ST_ERROR;
                  end
               end
               PH_SEND_FRAME, PH_WAIT_EACK: begin
                  if (b == msol_pkg::ACK_OK) begin
                     phase_in = PH_WAIT_ROP;
                     ticks_in = timeout_ff;
                  end else begin
                     phase_in = PH_READY;
                     held_in  = msol_pkg::ST_ERROR;
                  end
               end
               PH_WAIT_ROP: begin
                  ack_ok_in     = (b == 8'h00);
                  desc.count    = 4'd1;
                  desc.bytes[0] = ack_ok_in ? msol_pkg::ACK_OK : msol_pkg::ACK_FAIL;
                  phase_in      = PH_SEND_RBACK;
                  ticks_in      = timeout_ff;
               end
               PH_SEND_RBACK: coll = ack_ok_ff;
               PH_WAIT_RPAY:  coll = 1'b1;
               default: ;
            endcase
         end
         msol_pkg::REQ_DRAIN: begin
            unique case (phase_ff)
               PH_SEND_OP:    phase_in = PH_WAIT_BACK;
               PH_SEND_FRAME: phase_in = PH_WAIT_EACK;
               PH_SEND_RBACK: begin
                  if (ack_ok_ff) begin
                     phase_in = PH_WAIT_RPAY;
                  end else begin
                     phase_in = PH_READY;
                     held_in  = msol_pkg::ST_ERROR;
                  end
               end
               PH_SEND_REACK: begin
                  phase_in = PH_READY;
                  held_in  = ack_ok_ff ? msol_pkg::ST_SUCCESS : msol_pkg::ST_ERROR;
               end
               default: ;
            endcase
         end
         msol_pkg::REQ_TICK: begin
            if (phase_ff != PH_READY) begin
               if (ticks_ff <= 16'd1) begin
                  ticks_in = 16'd0;
                  phase_in = PH_READY;
                  held_in  = msol_pkg::ST_ERROR;
               end else begin
                  ticks_in = ticks_ff - 16'd1;
               end
            end
         end
         default: ;
      endcase

      // reply payload: the CRC runs as bytes arrive, low byte of a word held back
      if (coll) begin
         rc_in = rc_ff + 4'd1;
         if (rc_ff >= 4'd1 && rc_ff <= 4'd8) inb_in[rc_ff] = b;
         if (rc_ff == 4'd0) begin
            rcrc_in = msol_pkg::crc_step(16'h0000, b);
         end else if (rc_ff <= exp_ff - 4'd3) begin
            if (rc_ff[0]) begin
               pend_in = b;
            end else begin
               rcrc_in = msol_pkg::crc_step(msol_pkg::crc_step(rcrc_ff, b), pend_ff);
            end
         end else if (rc_ff == exp_ff - 4'd2) begin
            pend_in = b;
         end
         if (rc_in == exp_ff) begin
            ack_ok_in     = (rcrc_ff == {b, pend_ff});
            desc.count    = 4'd1;
            desc.bytes[0] = ack_ok_in ? msol_pkg::ACK_OK : msol_pkg::ACK_FAIL;
            phase_in      = PH_SEND_REACK;
            ticks_in      = timeout_ff;
         end
      end

      st = rejected ? msol_pkg::ST_BUSY : held_in;
      desc.status = st;
      if (st == msol_pkg::ST_SUCCESS) begin
         desc.err = {inb_ff[4], inb_ff[3], inb_ff[2], inb_ff[1]};
         if (exp_ff == 4'd11) desc.dat = {inb_ff[8], inb_ff[7], inb_ff[6], inb_ff[5]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_READY;
         timeout_ff <= msol_pkg::TIMEOUT_RESET;
         ticks_ff   <= 16'd0;
         held_ff    <= msol_pkg::ST_NONE;
         rc_ff      <= 4'd0;
         exp_ff     <= 4'd0;
         ack_ok_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) timeout_ff <= csr_wr_data;
         if (accept) begin
            phase_ff  <= phase_in;
            ticks_ff  <= ticks_in;
            held_ff   <= held_in;
            rc_ff     <= rc_in;
            exp_ff    <= exp_in;
            ack_ok_ff <= ack_ok_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         is_wr_ff <= is_wr_in;
         out_ff   <= out_in;
         inb_ff   <= inb_in;
         rcrc_ff  <= rcrc_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/msol_serializer.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msol_serializer (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    load,
   input  wire msol_pkg::msol_desc_type desc,
   output logic                         free,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output msol_pkg::msol_rsp_type       rsp_data
);

   msol_pkg::msol_desc_type desc_ff;
   logic       valid_ff;
   logic [3:0] idx_ff;
   logic       last;

   assign last = (desc_ff.count == 4'd0) || (idx_ff == desc_ff.count - 4'd1);
   assign free = !valid_ff || (!rsp_stall && last);

   assign rsp_valid                 = valid_ff;
   assign rsp_data.tx_valid         = (desc_ff.count != 4'd0);
   assign rsp_data.tx_byte          = desc_ff.bytes[idx_ff];
   assign rsp_data.last             = last;
   assign rsp_data.link_status      = desc_ff.status;
   assign rsp_data.reply_error_code = desc_ff.err;
   assign rsp_data.reply_data       = desc_ff.dat;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 4'd0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= 4'd0;
      end else if (valid_ff && !rsp_stall) begin
         if (last) valid_ff <= 1'b0;
         idx_ff <= idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) desc_ff <= desc;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/motor_drive_serial_object_link.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel | ports                              | carries
// --------+------------------------------------+-------------------------------
// req     | req_valid, req_stall, req_data     | one event word per accept
// rsp     | rsp_valid, rsp_stall, rsp_data     | 1 to 11 words per event word
// csr     | csr_wr_en, csr_wr_data             | timeout_ticks, no read-back
//
// An event word is decoded in the cycle it is accepted; its results sit in the
// serializer from the next cycle, one word per cycle that rsp_stall is low.
// The input takes a new word in the same cycle the last result of the previous
// one leaves, and none while earlier results are still going out (the
// outbound frame burst of 7 or 11 bytes is the long case).
// Reset is synchronous: link idle, status none, timeout 500 ticks.
// A stall on rsp holds the current result and, through req_stall, the input.

module motor_drive_serial_object_link (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire msol_pkg::msol_req_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output msol_pkg::msol_rsp_type      rsp_data,
   input  wire logic                   csr_wr_en,
   input  wire logic [15:0]            csr_wr_data
);

   msol_pkg::msol_desc_type desc;
   logic free;
   logic accept;

   assign req_stall = !free;
   assign accept    = req_valid && free;

   // protocol engine: link phase, frames, CRCs, timeout
   msol_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .desc        (desc)
   );

   // result register, walks the tx bytes out one word at a time
   msol_serializer u_ser (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .desc      (desc),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/msol_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msol_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_stall,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire msol_pkg::msol_rsp_type rsp_data
);

   // an accepted event word shows its first result on the next cycle
   a_accept_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("no result after accept");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed under stall");

   // a word with nothing to send is the only result of its event
   a_notx_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.tx_valid |-> rsp_data.last && rsp_data.tx_byte == 8'h00)
      else $error("silent result not last");

   // reply fields only show on success
   a_reply_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.link_status != msol_pkg::ST_SUCCESS
      |-> rsp_data.reply_error_code == 32'h0 && rsp_data.reply_data == 32'h0)
      else $error("reply data without success");

   // input is held while a burst is still going out
   a_burst_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> req_stall)
      else $error("input taken mid burst");

endmodule

bind motor_drive_serial_object_link msol_checker u_msol_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE      = 30;    // cycles of quiet before a timeout write or the end
   localparam int LONG_HOLD   = 300;   // receiver hold-off in the first phase

   // link phases of the host side
   typedef enum logic [3:0] {
      LK_READY, LK_SEND_OP, LK_WAIT_BACK, LK_SEND_FRAME, LK_WAIT_EACK,
      LK_WAIT_ROP, LK_SEND_RBACK, LK_WAIT_RPAY, LK_SEND_REACK
   } link_phase_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   msol_pkg::msol_req_type req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   msol_pkg::msol_rsp_type rsp_data;
   logic                   csr_wr_en = 1'b0;
   logic [15:0]            csr_wr_data = '0;

   motor_drive_serial_object_link dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Predicted link state; shadows the block word for word.
   // ---------------------------------------------------------------
   logic [15:0]    timeout_shadow = msol_pkg::TIMEOUT_RESET;
   link_phase_type lk_phase = LK_READY;
   logic [7:0]     out_frame [msol_pkg::FRAME_MAX];
   logic [7:0]     in_frame  [msol_pkg::FRAME_MAX];
   int unsigned    rx_count = 0;
   int unsigned    reply_len = 0;
   logic           last_ack_ok = 1'b0;
   logic [15:0]    ticks_left = '0;
   logic [2:0]     held_status = msol_pkg::ST_NONE;

   logic [7:0]             tx_bytes [$];        // bytes one event word sends
   msol_pkg::msol_rsp_type expected_words [$];  // results still owed by the block
   msol_pkg::msol_req_type stim_q [$];          // event words waiting for the driver

   int unsigned  errors = 0;
   int unsigned  phase_no = 0;
   int unsigned  send_idle = 0;
   int unsigned  recv_idle = 0;
   int unsigned  stim_count = 0;

   // CRC-16/0x1021, MSB first, one byte
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   // frame CRC: length byte, then each LE word taken high byte first
   function automatic logic [15:0] frame_crc(input logic [15:0] seed,
                                             input logic [7:0] f [msol_pkg::FRAME_MAX],
                                             input int nwordbytes);
      logic [15:0] c;
      c = crc16_byte(seed, f[0]);
      for (int i = 1; i + 1 < 1 + nwordbytes + 1; i += 2) begin
         c = crc16_byte(c, f[i + 1]);
         c = crc16_byte(c, f[i]);
      end
      return c;
   endfunction

   task automatic link_abort();
      lk_phase    = LK_READY;
      held_status = msol_pkg::ST_ERROR;
   endtask

   task automatic link_open(input msol_pkg::msol_req_type w);
      logic        is_wr;
      logic [7:0]  op;
      int          dl;
      logic [15:0] c;
      is_wr = (w.req_type == msol_pkg::REQ_WRITE);
      op    = is_wr ? msol_pkg::OP_WRITE : msol_pkg::OP_READ;
      dl    = is_wr ? 8 : 4;
      out_frame[0] = is_wr ? 8'd3 : 8'd1;
      out_frame[1] = w.object_index[7:0];
      out_frame[2] = w.object_index[15:8];
      out_frame[3] = w.object_subindex;
      out_frame[4] = w.node_id;
      if (is_wr) begin
         for (int i = 0; i < 4; i++) out_frame[5 + i] = w.write_value[8*i +: 8];
      end
      c = frame_crc(crc16_byte(16'h0000, op), out_frame, dl);
      out_frame[1 + dl] = c[7:0];
      out_frame[2 + dl] = c[15:8];
      reply_len   = is_wr ? 7 : 11;
      rx_count    = 0;
      last_ack_ok = 1'b0;
      lk_phase    = LK_SEND_OP;
      held_status = msol_pkg::ST_WAIT;
      ticks_left  = timeout_shadow;
      tx_bytes.push_back(op);
   endtask

   task automatic link_collect(input logic [7:0] b);
      logic [15:0] c;
      logic [15:0] got;
      if (rx_count < msol_pkg::FRAME_MAX && rx_count < reply_len) in_frame[rx_count] = b;
      rx_count++;
      if (rx_count < reply_len) return;
      c   = frame_crc(16'h0000, in_frame, int'(reply_len) - 3);
      got = {in_frame[reply_len - 1], in_frame[reply_len - 2]};
      last_ack_ok = (c == got);
      tx_bytes.push_back(last_ack_ok ? msol_pkg::ACK_OK : msol_pkg::ACK_FAIL);
      lk_phase   = LK_SEND_REACK;
      ticks_left = timeout_shadow;
   endtask

   // expected results of one accepted event word
   task automatic link_predict(input msol_pkg::msol_req_type w);
      logic                   rejected;
      logic [2:0]             st;
      logic [31:0]            err;
      logic [31:0]            dat;
      int                     cnt;
      int                     flen;
      msol_pkg::msol_rsp_type r;
      rejected = 1'b0;
      err = '0;
      dat = '0;
      tx_bytes.delete();
      case (w.req_type) inside
         msol_pkg::REQ_WRITE, msol_pkg::REQ_READ: begin
            if (lk_phase != LK_READY) rejected = 1'b1;
            else link_open(w);
         end
         msol_pkg::REQ_BYTE: begin
            case (lk_phase) inside
               LK_SEND_OP, LK_WAIT_BACK: begin
                  if (w.rx_byte == msol_pkg::ACK_OK) begin
                     flen = (out_frame[0] == 8'd3) ? 11 : 7;
                     for (int k = 0; k < flen; k++) tx_bytes.push_back(out_frame[k]);
                     lk_phase   = LK_SEND_FRAME;
                     ticks_left = timeout_shadow;
                  end else begin
                     link_abort();
                  end
               end
               LK_SEND_FRAME, LK_WAIT_EACK: begin
                  if (w.rx_byte == msol_pkg::ACK_OK) begin
                     lk_phase   = LK_WAIT_ROP;
                     ticks_left = timeout_shadow;
                  end else begin
                     link_abort();
                  end
               end
               LK_WAIT_ROP: begin
                  last_ack_ok = (w.rx_byte == 8'h00);
                  tx_bytes.push_back(last_ack_ok ? msol_pkg::ACK_OK : msol_pkg::ACK_FAIL);
                  lk_phase   = LK_SEND_RBACK;
                  ticks_left = timeout_shadow;
               end
               LK_SEND_RBACK: if (last_ack_ok) link_collect(w.rx_byte);
               LK_WAIT_RPAY:  link_collect(w.rx_byte);
               default: ;
            endcase
         end
         msol_pkg::REQ_DRAIN: begin
            case (lk_phase)
               LK_SEND_OP:    lk_phase = LK_WAIT_BACK;
               LK_SEND_FRAME: lk_phase = LK_WAIT_EACK;
               LK_SEND_RBACK: begin
                  if (last_ack_ok) lk_phase = LK_WAIT_RPAY;
                  else link_abort();
               end
               LK_SEND_REACK: begin
                  if (last_ack_ok) begin
                     lk_phase    = LK_READY;
                     held_status = msol_pkg::ST_SUCCESS;
                  end else begin
                     link_abort();
                  end
               end
               default: ;
            endcase
         end
         msol_pkg::REQ_TICK: begin
            if (lk_phase != LK_READY) begin
               if (ticks_left <= 16'd1) begin
                  ticks_left = '0;
                  link_abort();
               end else begin
                  ticks_left--;
               end
            end
         end
         default: ;   // unused types fall through untouched
      endcase

      st = rejected ? msol_pkg::ST_BUSY : held_status;
      if (st == msol_pkg::ST_SUCCESS) begin
         err = {in_frame[4], in_frame[3], in_frame[2], in_frame[1]};
         if (reply_len == 11) dat = {in_frame[8], in_frame[7], in_frame[6], in_frame[5]};
      end
      cnt = (tx_bytes.size() > 0) ? tx_bytes.size() : 1;
      for (int k = 0; k < cnt; k++) begin
         r.tx_valid         = (tx_bytes.size() > 0);
         r.tx_byte          = (tx_bytes.size() > 0) ? tx_bytes[k] : 8'h00;
         r.last             = (k == cnt - 1);
         r.link_status      = st;
         r.reply_error_code = err;
         r.reply_data       = dat;
         expected_words.push_back(r);
      end
   endtask

   // ---------------------------------------------------------------
   // Driver: presents queued words, holds them while stalled.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) link_predict(req_data);
         if (!req_valid || !req_stall) begin
            if (stim_q.size() > 0 && $urandom_range(99) >= send_idle) begin
               req_data  <= stim_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Long receiver hold-off in the first phase; the sender keeps
   // offering while it lasts, so req_stall must rise.
   // ---------------------------------------------------------------
   int unsigned hold_count = 0;
   logic        hold_on = 1'b0;

   always @(posedge clock) begin
      if (!reset && phase_no == 0 && stim_q.size() > 0 && hold_count < LONG_HOLD) begin
         hold_count++;
         hold_on <= 1'b1;
      end else begin
         hold_on <= 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // Monitor: random stall plus the hold-off above, and a
   // field-by-field check of every accepted word.
   // ---------------------------------------------------------------
   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   always @(posedge clock) begin
      msol_pkg::msol_rsp_type w;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               report("unexpected result", 32'(rsp_data.tx_byte), 32'h0);
            end else begin
               w = expected_words.pop_front();
               if (rsp_data.tx_valid !== w.tx_valid)
                  report("tx_valid", 32'(rsp_data.tx_valid), 32'(w.tx_valid));
               if (rsp_data.tx_byte !== w.tx_byte)
                  report("tx_byte", 32'(rsp_data.tx_byte), 32'(w.tx_byte));
               if (rsp_data.last !== w.last)
                  report("last", 32'(rsp_data.last), 32'(w.last));
               if (rsp_data.link_status !== w.link_status)
                  report("link_status", 32'(rsp_data.link_status), 32'(w.link_status));
               if (rsp_data.reply_error_code !== w.reply_error_code)
                  report("reply_error_code", rsp_data.reply_error_code, w.reply_error_code);
               if (rsp_data.reply_data !== w.reply_data)
                  report("reply_data", rsp_data.reply_data, w.reply_data);
            end
         end
         if (hold_on) begin
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle);
         end
      end
   end

   // ---------------------------------------------------------------
   // Cycle limit
   // ---------------------------------------------------------------
   int unsigned cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus builders
   // ---------------------------------------------------------------
   function automatic msol_pkg::msol_req_type make_word(input logic [2:0] t,
                                                       input logic [7:0] b);
      msol_pkg::msol_req_type w;
      w.req_type        = t;
      w.object_index    = 16'($urandom_range(16'hFFFF));
      w.object_subindex = 8'($urandom_range(8'hFF));
      w.node_id         = 8'($urandom_range(8'hFF));
      w.write_value     = $urandom;
      w.rx_byte         = b;
      return w;
   endfunction

   task automatic push_word(input logic [2:0] t, input logic [7:0] b);
      stim_q.push_back(make_word(t, b));
      stim_count++;
   endtask

   // occasional noise: ticks, busy requests, unused types
   task automatic maybe_noise();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 8) push_word(msol_pkg::REQ_TICK, 8'($urandom_range(8'hFF)));
      else if (r < 11) push_word(3'($urandom_range(1)), 8'($urandom_range(8'hFF)));
      else if (r < 13) push_word(3'($urandom_range(7, 5)), 8'($urandom_range(8'hFF)));
   endtask

   // an ack byte that is usually good, around a drain in either order
   task automatic ack_stage(input int bad_pct);
      logic [7:0] a;
      a = ($urandom_range(99) < bad_pct) ? 8'($urandom_range(8'hFF)) : msol_pkg::ACK_OK;
      if ($urandom_range(99) < 80) begin
         push_word(msol_pkg::REQ_DRAIN, 8'($urandom_range(8'hFF)));
         maybe_noise();
         push_word(msol_pkg::REQ_BYTE, a);
      end else begin
         push_word(msol_pkg::REQ_BYTE, a);   // byte before the transmit has drained
         push_word(msol_pkg::REQ_DRAIN, 8'($urandom_range(8'hFF)));
      end
      maybe_noise();
   endtask

   // one exchange, mostly well formed, with random content
   task automatic add_exchange();
      logic [2:0]  t;
      int          len;
      int          early;
      logic [7:0]  pay [msol_pkg::FRAME_MAX];
      logic [15:0] c;
      t   = $urandom_range(1) ? msol_pkg::REQ_WRITE : msol_pkg::REQ_READ;
      len = (t == msol_pkg::REQ_WRITE) ? 7 : 11;
      push_word(t, 8'($urandom_range(8'hFF)));
      maybe_noise();
      ack_stage(5);
      ack_stage(5);
      push_word(msol_pkg::REQ_BYTE,
                ($urandom_range(99) < 10) ? 8'($urandom_range(1, 255)) : 8'h00);
      foreach (pay[i]) pay[i] = 8'($urandom_range(8'hFF));
      c = frame_crc(16'h0000, pay, len - 3);
      pay[len - 2] = c[7:0];
      pay[len - 1] = c[15:8];
      if ($urandom_range(99) < 15) pay[$urandom_range(len - 1)] ^= 8'h01 << $urandom_range(7);
      early = ($urandom_range(99) < 15) ? $urandom_range(1, 3) : 0;
      for (int i = 0; i < early; i++) push_word(msol_pkg::REQ_BYTE, pay[i]);
      push_word(msol_pkg::REQ_DRAIN, 8'($urandom_range(8'hFF)));
      for (int i = early; i < len; i++) begin
         push_word(msol_pkg::REQ_BYTE, pay[i]);
         if ($urandom_range(99) < 4) push_word(msol_pkg::REQ_TICK, 8'($urandom_range(8'hFF)));
      end
      push_word(msol_pkg::REQ_BYTE, 8'($urandom_range(8'hFF)));   // stray byte during final ack
      push_word(msol_pkg::REQ_DRAIN, 8'($urandom_range(8'hFF)));
   endtask

   task automatic timeout_write(input logic [15:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      timeout_shadow = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_drained();
      wait (stim_q.size() == 0 && !req_valid && expected_words.size() == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // Phases
   // ---------------------------------------------------------------
   initial begin
      msol_pkg::msol_req_type w;
      logic [15:0] tmo_values [4];
      int unsigned send_pct [4];
      int unsigned recv_pct [4];
      tmo_values = '{msol_pkg::TIMEOUT_RESET, 16'hFFFF, 16'd1, 16'd0};
      send_pct   = '{0, 66, 0, 25};
      recv_pct   = '{0, 0, 66, 25};
      foreach (in_frame[i]) in_frame[i] = '0;
      foreach (out_frame[i]) out_frame[i] = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: idle events, all-ones write, busy, bad ack, all-zero read
      push_word(msol_pkg::REQ_BYTE, 8'hFF);
      push_word(msol_pkg::REQ_DRAIN, 8'h00);
      push_word(msol_pkg::REQ_TICK, 8'h00);
      push_word(3'd7, 8'hFF);
      w = '1;
      w.req_type = msol_pkg::REQ_WRITE;
      stim_q.push_back(w);
      push_word(msol_pkg::REQ_READ, 8'h00);             // rejected, exchange goes on
      push_word(msol_pkg::REQ_DRAIN, 8'h00);
      push_word(msol_pkg::REQ_BYTE, msol_pkg::ACK_FAIL);  // bad ack, error
      w = '0;
      w.req_type = msol_pkg::REQ_READ;
      stim_q.push_back(w);
      push_word(msol_pkg::REQ_BYTE, msol_pkg::ACK_OK);    // early ack before drain
      push_word(msol_pkg::REQ_DRAIN, 8'h00);
      push_word(msol_pkg::REQ_BYTE, msol_pkg::ACK_OK);
      push_word(msol_pkg::REQ_BYTE, 8'h05);             // nonzero reply opcode, answered 'F'
      push_word(msol_pkg::REQ_BYTE, 8'h00);             // ignored after an 'F'
      push_word(msol_pkg::REQ_DRAIN, 8'h00);            // error
      stim_count = 0;

      for (int p = 0; p < 4; p++) begin
         if (p > 0) timeout_write(tmo_values[p]);
         @(negedge clock);
         send_idle = send_pct[p];
         recv_idle = recv_pct[p];
         phase_no  = p;
         stim_count = 0;
         while (stim_count < 25) add_exchange();
         wait_drained();
      end

      if (errors == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/msol_pkg.sv
hw/rtl/msol_ctrl.sv
hw/rtl/msol_serializer.sv
hw/rtl/motor_drive_serial_object_link.sv
hw/rtl/msol_checker.sv
sim/tb.sv
